>>> hw/rtl/rhsv_pkg.sv
// rhsv_pkg: shared constants for the RGB to HSV pipeline.
// No dependencies.
package rhsv_pkg;

    localparam int HUE_BITS = 16;
    localparam int SAT_BITS = 17;

endpackage

>>> hw/rtl/rhsv_front.sv
// rhsv_front: three register stages that find max, min, sector, channel difference,
// and set up the dividends and divisors for hue and saturation. Uses rhsv_pkg.
module rhsv_front
    import rhsv_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [CHANNEL_BITS-1:0]   red,
    input  logic [CHANNEL_BITS-1:0]   green,
    input  logic [CHANNEL_BITS-1:0]   blue,
    output logic                      out_valid,
    output logic [CHANNEL_BITS-1:0]   out_hi,
    output logic [CHANNEL_BITS-1:0]   out_sdiv,
    output logic [CHANNEL_BITS-1:0]   out_srem,
    output logic [SAT_BITS-1:0]       out_satq,
    output logic [CHANNEL_BITS+2:0]   out_den,
    output logic [CHANNEL_BITS+2:0]   out_hrem
);

    localparam int N  = CHANNEL_BITS;
    localparam int NW = CHANNEL_BITS + 3;

    typedef enum logic [1:0] {SECT_RED, SECT_GREEN, SECT_BLUE} sector_t;

    // stage 1
    logic              v1_reg;
    logic [N-1:0]      hi1_reg, hi1_next;
    logic [N-1:0]      lo1_reg, lo1_next;
    sector_t           sec1_reg, sec1_next;
    logic signed [N:0] diff1_reg, diff1_next;

    // stage 2
    logic              v2_reg;
    logic [N-1:0]      hi2_reg;
    logic [N-1:0]      span2_reg, span2_next;
    sector_t           sec2_reg;
    logic signed [N:0] diff2_reg;

    // stage 3
    logic              v3_reg;
    logic [N-1:0]      hi3_reg;
    logic [N-1:0]      sdiv3_reg, sdiv3_next;
    logic [N-1:0]      srem3_reg, srem3_next;
    logic              q16_reg, q16_next;
    logic [NW-1:0]     den3_reg, den3_next;
    logic [NW-1:0]     num3_reg, num3_next;

    logic [NW-1:0]       six_span;
    logic signed [NW:0]  diff_ext;
    logic signed [NW:0]  num_s;

    always_comb begin
        hi1_next = red;
        if (green > hi1_next) hi1_next = green;
        if (blue > hi1_next) hi1_next = blue;
        lo1_next = red;
        if (green < lo1_next) lo1_next = green;
        if (blue < lo1_next) lo1_next = blue;
        if (hi1_next == blue) begin
            sec1_next  = SECT_BLUE;
            diff1_next = $signed({1'b0, red}) - $signed({1'b0, green});
        end else if (hi1_next == green) begin
            sec1_next  = SECT_GREEN;
            diff1_next = $signed({1'b0, blue}) - $signed({1'b0, red});
        end else begin
            sec1_next  = SECT_RED;
            diff1_next = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
    end

    assign span2_next = hi1_reg - lo1_reg;

    always_comb begin
        six_span = ({3'b000, span2_reg} << 2) + ({3'b000, span2_reg} << 1);
        diff_ext = {{3{diff2_reg[N]}}, diff2_reg};
        case (sec2_reg)
            SECT_BLUE:  num_s = $signed({2'b00, span2_reg, 2'b00}) + diff_ext;
            SECT_GREEN: num_s = $signed({3'b000, span2_reg, 1'b0}) + diff_ext;
            default: begin
                // red sector: negative hue wraps by a full turn
                if (diff_ext < 0) num_s = diff_ext + $signed({1'b0, six_span});
                else num_s = diff_ext;
            end
        endcase
        num3_next = num_s[NW-1:0];
        den3_next = (span2_reg == '0) ? {{(NW-1){1'b0}}, 1'b1} : six_span;
        sdiv3_next = (hi2_reg == '0) ? {{(N-1){1'b0}}, 1'b1} : hi2_reg;
        q16_next   = (span2_reg >= sdiv3_next);
        srem3_next = q16_next ? (span2_reg - sdiv3_next) : span2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hi1_reg   <= hi1_next;
            lo1_reg   <= lo1_next;
            sec1_reg  <= sec1_next;
            diff1_reg <= diff1_next;
            hi2_reg   <= hi1_reg;
            span2_reg <= span2_next;
            sec2_reg  <= sec1_reg;
            diff2_reg <= diff1_reg;
            hi3_reg   <= hi2_reg;
            sdiv3_reg <= sdiv3_next;
            srem3_reg <= srem3_next;
            q16_reg   <= q16_next;
            den3_reg  <= den3_next;
            num3_reg  <= num3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_hi    = hi3_reg;
    assign out_sdiv  = sdiv3_reg;
    assign out_srem  = srem3_reg;
    assign out_satq  = {{(SAT_BITS-1){1'b0}}, q16_reg};
    assign out_den   = den3_reg;
    assign out_hrem  = num3_reg;

endmodule

>>> hw/rtl/rhsv_div_stage.sv
// rhsv_div_stage: one restoring division step for hue and for saturation,
// one quotient bit of each per stage. Uses rhsv_pkg.
module rhsv_div_stage
    import rhsv_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [CHANNEL_BITS-1:0]   in_hi,
    input  logic [CHANNEL_BITS-1:0]   in_sdiv,
    input  logic [CHANNEL_BITS-1:0]   in_srem,
    input  logic [SAT_BITS-1:0]       in_satq,
    input  logic [CHANNEL_BITS+2:0]   in_den,
    input  logic [CHANNEL_BITS+2:0]   in_hrem,
    input  logic [HUE_BITS-1:0]       in_hueq,
    output logic                      out_valid,
    output logic [CHANNEL_BITS-1:0]   out_hi,
    output logic [CHANNEL_BITS-1:0]   out_sdiv,
    output logic [CHANNEL_BITS-1:0]   out_srem,
    output logic [SAT_BITS-1:0]       out_satq,
    output logic [CHANNEL_BITS+2:0]   out_den,
    output logic [CHANNEL_BITS+2:0]   out_hrem,
    output logic [HUE_BITS-1:0]       out_hueq
);

    localparam int N  = CHANNEL_BITS;
    localparam int NW = CHANNEL_BITS + 3;

    logic            valid_reg;
    logic [N-1:0]    hi_reg, sdiv_reg;
    logic [N-1:0]    srem_reg, srem_next;
    logic [SAT_BITS-1:0] satq_reg, satq_next;
    logic [NW-1:0]   den_reg;
    logic [NW-1:0]   hrem_reg, hrem_next;
    logic [HUE_BITS-1:0] hueq_reg, hueq_next;

    logic [N:0]  s_trial;
    logic [NW:0] h_trial;
    logic        s_bit, h_bit;

    always_comb begin
        s_trial   = {in_srem, 1'b0};
        s_bit     = (s_trial >= {1'b0, in_sdiv});
        srem_next = s_bit ? N'(s_trial - {1'b0, in_sdiv}) : s_trial[N-1:0];
        satq_next = {in_satq[SAT_BITS-2:0], s_bit};

        h_trial   = {in_hrem, 1'b0};
        h_bit     = (h_trial >= {1'b0, in_den});
        hrem_next = h_bit ? NW'(h_trial - {1'b0, in_den}) : h_trial[NW-1:0];
        hueq_next = {in_hueq[HUE_BITS-2:0], h_bit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hi_reg   <= in_hi;
            sdiv_reg <= in_sdiv;
            srem_reg <= srem_next;
            satq_reg <= satq_next;
            den_reg  <= in_den;
            hrem_reg <= hrem_next;
            hueq_reg <= hueq_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_hi    = hi_reg;
    assign out_sdiv  = sdiv_reg;
    assign out_srem  = srem_reg;
    assign out_satq  = satq_reg;
    assign out_den   = den_reg;
    assign out_hrem  = hrem_reg;
    assign out_hueq  = hueq_reg;

endmodule

>>> hw/rtl/rgb_to_hsv_pixel.sv
// rgb_to_hsv_pixel: RGB to HSV pixel converter, top level. Uses rhsv_pkg,
// rhsv_front and rhsv_div_stage.
// Pipeline: 3 setup stages, then 16 divider stages.
// Throughput: one word per cycle unless back-pressure stalls; the divider is unrolled one quotient bit per stage.
// Back-pressure stalls the whole pipeline; nothing is dropped or repeated.
// Reset: synchronous active-low aresetn clears all stage valid bits.
module rgb_to_hsv_pixel
    import rhsv_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [CHANNEL_BITS-1:0] s_red,
    input  logic [CHANNEL_BITS-1:0] s_green,
    input  logic [CHANNEL_BITS-1:0] s_blue,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [HUE_BITS-1:0]     m_hue,
    output logic [SAT_BITS-1:0]     m_saturation,
    output logic [CHANNEL_BITS-1:0] m_brightness
);

    localparam int N      = CHANNEL_BITS;
    localparam int NW     = CHANNEL_BITS + 3;
    localparam int STAGES = HUE_BITS;

    logic                en;
    logic                v_c    [0:STAGES];
    logic [N-1:0]        hi_c   [0:STAGES];
    logic [N-1:0]        sdiv_c [0:STAGES];
    logic [N-1:0]        srem_c [0:STAGES];
    logic [SAT_BITS-1:0] satq_c [0:STAGES];
    logic [NW-1:0]       den_c  [0:STAGES];
    logic [NW-1:0]       hrem_c [0:STAGES];
    logic [HUE_BITS-1:0] hueq_c [0:STAGES];

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    rhsv_front #(.CHANNEL_BITS(CHANNEL_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .red       (s_red),
        .green     (s_green),
        .blue      (s_blue),
        .out_valid (v_c[0]),
        .out_hi    (hi_c[0]),
        .out_sdiv  (sdiv_c[0]),
        .out_srem  (srem_c[0]),
        .out_satq  (satq_c[0]),
        .out_den   (den_c[0]),
        .out_hrem  (hrem_c[0])
    );

    assign hueq_c[0] = '0;

    for (genvar i = 0; i < STAGES; i++) begin : g_div
        rhsv_div_stage #(.CHANNEL_BITS(CHANNEL_BITS)) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (v_c[i]),
            .in_hi     (hi_c[i]),
            .in_sdiv   (sdiv_c[i]),
            .in_srem   (srem_c[i]),
            .in_satq   (satq_c[i]),
            .in_den    (den_c[i]),
            .in_hrem   (hrem_c[i]),
            .in_hueq   (hueq_c[i]),
            .out_valid (v_c[i+1]),
            .out_hi    (hi_c[i+1]),
            .out_sdiv  (sdiv_c[i+1]),
            .out_srem  (srem_c[i+1]),
            .out_satq  (satq_c[i+1]),
            .out_den   (den_c[i+1]),
            .out_hrem  (hrem_c[i+1]),
            .out_hueq  (hueq_c[i+1])
        );
    end

    assign m_valid      = v_c[STAGES];
    assign m_hue        = hueq_c[STAGES];
    assign m_saturation = satq_c[STAGES];
    assign m_brightness = hi_c[STAGES];

    a_sat_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_saturation <= {1'b1, {(SAT_BITS-1){1'b0}}})
        else $error("saturation above one");

    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_brightness == '0) |-> (m_saturation == '0 && m_hue == '0))
        else $error("black pixel with nonzero hue or saturation");

    a_gray: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturation == '0) |-> m_hue == '0)
        else $error("gray pixel with nonzero hue");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> v_c[0] == $past(v_c[0]) && hrem_c[0] == $past(hrem_c[0]))
        else $error("front stage moved during stall");

endmodule

>>> dv/rgb_to_hsv_pixel_tb.sv
// rgb_to_hsv_pixel_tb: self-checking bench for the RGB to HSV pixel converter.
// Predicts hue, saturation and value per pixel and checks every output word in order.
// Depends on rhsv_pkg and rgb_to_hsv_pixel.
module rgb_to_hsv_pixel_tb;
    import rhsv_pkg::*;

    localparam int CB          = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN       = 40;

    typedef logic [CB-1:0] chan_t;

    typedef struct packed {
        logic [HUE_BITS-1:0] hue;
        logic [SAT_BITS-1:0] sat;
        chan_t               val;
    } hsv_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    chan_t               s_red;
    chan_t               s_green;
    chan_t               s_blue;
    logic                m_valid;
    logic                m_ready;
    logic [HUE_BITS-1:0] m_hue;
    logic [SAT_BITS-1:0] m_saturation;
    chan_t               m_brightness;

    hsv_t pending_hsv[$];
    int   err_count     = 0;
    int   cycle_count   = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;

    rgb_to_hsv_pixel #(.CHANNEL_BITS(CB)) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hue        (m_hue),
        .m_saturation (m_saturation),
        .m_brightness (m_brightness)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic hsv_t predict_hsv(chan_t r, chan_t g, chan_t b);
        longint rr, gg, bb, hi, lo, span, num;
        hsv_t   res;
        rr = r;
        gg = g;
        bb = b;
        hi = rr;
        if (gg > hi) hi = gg;
        if (bb > hi) hi = bb;
        lo = rr;
        if (gg < lo) lo = gg;
        if (bb < lo) lo = bb;
        span = hi - lo;
        res = '0;
        res.val = chan_t'(hi);
        if (hi != 0) res.sat = SAT_BITS'((span << 16) / hi);
        if (span != 0) begin
            if (hi == bb) num = 4 * span + (rr - gg);
            else if (hi == gg) num = 2 * span + (bb - rr);
            else num = gg - bb;
            if (num < 0) num += 6 * span;
            res.hue = HUE_BITS'((num << 16) / (6 * span));
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
        err_count++;
    endtask

    // Entered and left at a falling edge.
    task automatic send_pixel(chan_t r, chan_t g, chan_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            s_red   = chan_t'($urandom);
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_red   = r;
        s_green = g;
        s_blue  = b;
        do @(posedge aclk); while (!s_ready);
        pending_hsv.push_back(predict_hsv(r, g, b));
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        hsv_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_hsv.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = pending_hsv.pop_front();
                if (m_hue !== want.hue) report_mismatch("hue", m_hue, want.hue);
                if (m_saturation !== want.sat)
                    report_mismatch("saturation", m_saturation, want.sat);
                if (m_brightness !== want.val)
                    report_mismatch("brightness", m_brightness, want.val);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic test_extremes();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd254, 8'd254);
    endtask

    task automatic test_ties();
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd1, 8'd1, 8'd0);
        send_pixel(8'd0, 8'd1, 8'd1);
        send_pixel(8'd200, 8'd37, 8'd200);
    endtask

    task automatic test_hue_wrap();
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd200, 8'd50, 8'd100);
        send_pixel(8'd255, 8'd1, 8'd0);
        send_pixel(8'd3, 8'd0, 8'd2);
    endtask

    task automatic test_random(int count);
        chan_t r, g, b;
        repeat (count) begin
            r = chan_t'($urandom);
            g = chan_t'($urandom);
            b = chan_t'($urandom);
            case ($urandom_range(5))
                0: begin
                    case ($urandom_range(2))
                        0: g = r;
                        1: b = g;
                        default: b = r;
                    endcase
                end
                1: begin
                    g = r;
                    b = r;
                end
                2: begin
                    r = $urandom_range(1) ? 8'd255 : ($urandom_range(1) ? 8'd0 : r);
                    g = $urandom_range(1) ? 8'd255 : ($urandom_range(1) ? 8'd0 : g);
                    b = $urandom_range(1) ? 8'd255 : ($urandom_range(1) ? 8'd0 : b);
                end
                3: begin
                    r = chan_t'($urandom_range(7));
                    g = chan_t'($urandom_range(7));
                    b = chan_t'($urandom_range(7));
                end
                default: ;
            endcase
            send_pixel(r, g, b);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_red   = '0;
        s_green = '0;
        s_blue  = '0;
        m_ready = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 55;
        test_extremes();
        test_ties();
        test_hue_wrap();
        test_random(170);

        send_idle_pct = 55;
        recv_idle_pct = 28;
        test_random(170);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(170);

        while (pending_hsv.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
